### rtl/onms_pkg.sv
// Package: shared constants, payload structs and IoU unit interface types.
package onms_pkg;

   localparam int MAX_DETS = 64;
   localparam int IDX_W    = $clog2(MAX_DETS);
   localparam int CNT_W    = $clog2(MAX_DETS + 1);
   localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd29491;

   typedef struct packed {
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] box_width;
      logic [15:0] box_height;
      logic [15:0] objectness;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [5:0]  det_index;
      logic [15:0] score_out;
      logic        kept;
      logic        last_out;
   } rsp_type;

   typedef struct packed {
      logic [15:0] h;
      logic [15:0] w;
      logic [15:0] cy;
      logic [15:0] cx;
   } box_type;

   typedef struct packed {
      logic [15:0]      score;
      logic [IDX_W-1:0] idx;
   } sort_entry_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] tag;
      box_type          a;
      box_type          b;
   } iou_req_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] tag;
      logic             hit;
      logic             busy;
   } iou_rsp_type;

endpackage

### rtl/onms_iou.sv
// IoU test unit: pipelined intersection versus threshold times union compare.
module onms_iou (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          thr,
   input  onms_pkg::iou_req_type req,
   output onms_pkg::iou_rsp_type rsp
);
   import onms_pkg::*;

   logic [5:0]             v_ff;
   logic [IDX_W-1:0]       t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff;
   logic signed [19:0]     ow_ff, oh_ff;
   logic [15:0]            aw_ff, ah_ff, bw_ff, bh_ff;
   logic [35:0]            inter2_ff, inter3_ff, inter4_ff, inter5_ff;
   logic [31:0]            area_a_ff, area_b_ff;
   logic [35:0]            uni_ff;
   logic [33:0]            plo_ff, phi_ff;
   logic                   zero4_ff, zero5_ff, hit_ff;
   logic [51:0]            prod_ff;

   logic signed [18:0]     alx, arx, aly, ary, blx, brx, bly, bry;
   logic signed [18:0]     lx, rx, ly, ry;
   logic signed [19:0]     ow_in, oh_in;

   always_comb begin
      alx = $signed({2'b00, req.a.cx, 1'b0}) - $signed({3'b000, req.a.w});
      arx = $signed({2'b00, req.a.cx, 1'b0}) + $signed({3'b000, req.a.w});
      aly = $signed({2'b00, req.a.cy, 1'b0}) - $signed({3'b000, req.a.h});
      ary = $signed({2'b00, req.a.cy, 1'b0}) + $signed({3'b000, req.a.h});
      blx = $signed({2'b00, req.b.cx, 1'b0}) - $signed({3'b000, req.b.w});
      brx = $signed({2'b00, req.b.cx, 1'b0}) + $signed({3'b000, req.b.w});
      bly = $signed({2'b00, req.b.cy, 1'b0}) - $signed({3'b000, req.b.h});
      bry = $signed({2'b00, req.b.cy, 1'b0}) + $signed({3'b000, req.b.h});
      lx = (alx > blx) ? alx : blx;
      rx = (arx < brx) ? arx : brx;
      ly = (aly > bly) ? aly : bly;
      ry = (ary < bry) ? ary : bry;
      ow_in = 20'(rx) - 20'(lx);
      oh_in = 20'(ry) - 20'(ly);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[4:0], req.valid};
      end
      // edges and overlap extents
      t1_ff <= req.tag;
      ow_ff <= ow_in;
      oh_ff <= oh_in;
      aw_ff <= req.a.w;
      ah_ff <= req.a.h;
      bw_ff <= req.b.w;
      bh_ff <= req.b.h;
      // products
      t2_ff     <= t1_ff;
      inter2_ff <= (ow_ff < 0 || oh_ff < 0) ? 36'd0 : ow_ff[17:0] * oh_ff[17:0];
      area_a_ff <= aw_ff * ah_ff;
      area_b_ff <= bw_ff * bh_ff;
      // union of doubled-edge areas
      t3_ff     <= t2_ff;
      uni_ff    <= {2'b00, area_a_ff, 2'b00} + {2'b00, area_b_ff, 2'b00} - inter2_ff;
      inter3_ff <= inter2_ff;
      // threshold times union, split in two partial products
      t4_ff     <= t3_ff;
      plo_ff    <= thr * uni_ff[17:0];
      phi_ff    <= thr * uni_ff[35:18];
      zero4_ff  <= (uni_ff == 36'd0);
      inter4_ff <= inter3_ff;
      t5_ff     <= t4_ff;
      prod_ff   <= {phi_ff, 18'd0} + {18'd0, plo_ff};
      zero5_ff  <= zero4_ff;
      inter5_ff <= inter4_ff;
      t6_ff     <= t5_ff;
      hit_ff    <= !zero5_ff && ({inter5_ff, 16'd0} > prod_ff);
   end

   assign rsp.valid = v_ff[5];
   assign rsp.tag   = t6_ff;
   assign rsp.hit   = hit_ff;
   assign rsp.busy  = |v_ff;

endmodule

### rtl/objectness_nms_unit.sv
// Top level: detection store, insertion sort, greedy suppression and result stream.
//
// Usage: pulse start with a detection on req_data while busy is low; each such
// transfer loads one detection. Transfers with last_in low leave busy low. The
// transfer with last_in high ends the set (a detection that arrives with the
// store full is dropped, its last_in still counts) and raises busy for the
// whole run:
//   sort    : insertion sort in the order memory, each element compared with
//             those ranked ahead of it, each lower score shifted up a place
//   suppress: for each kept row, a setup (order read, check, box fetch), one
//             candidate pair per cycle streamed through the 6-stage IoU
//             pipeline, then a drain until it is empty; skipped rows only check
//   output  : n results, one per cycle, on rsp_data marked by rsp_strobe,
//             in sorted order, last_out on the final one
// The run time is set by the single order-memory read port in the sort and the
// one IoU unit in the suppression pass.
// The receiver takes every result in the cycle it is shown and cannot stall.
// csr_we writes iou_threshold (Q0.16); write it only while busy is low.
// Reset (synchronous) empties the store, clears the flags and sets the
// threshold to its default; memory contents are left as they are.
module objectness_nms_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  onms_pkg::req_type req_data,
   output logic              rsp_strobe,
   output onms_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);
   import onms_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SORT_RD, ST_SORT_V, ST_SORT_CMP, ST_SORT_PUT,
      ST_ROW_RD, ST_ROW_CHK, ST_ROW_BOX, ST_STREAM, ST_OUT
   } state_type;

   // memories
   box_type        box_mem   [MAX_DETS];
   logic [15:0]    score_mem [MAX_DETS];
   sort_entry_type sort_mem  [MAX_DETS];

   logic             box_we, sort_we;
   logic [IDX_W-1:0] box_wa, box_ra, score_ra, sort_wa, sort_ra;
   box_type          box_wd, box_rd_ff;
   logic [15:0]      score_rd_ff;
   sort_entry_type   sort_wd, sort_rd_ff;

   // control
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in, i_ff, i_in, j_ff, j_in;
   logic [CNT_W-1:0]      i_next, j_m1, j_m2;
   logic [15:0]           v_score_ff, v_score_in, thr_ff;
   logic [MAX_DETS-1:0]   supp_ff, supp_in;
   box_type               box_a_ff, box_a_in;
   logic                  s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic [IDX_W-1:0]      s2_tag_ff, s2_tag_in;
   logic                  pend_ff, pend_in, last_ff, last_in_nx;
   sort_entry_type        v_entry;
   iou_req_type           iou_req;
   iou_rsp_type           iou_rsp;

   assign i_next  = i_ff + 1'b1;
   assign j_m1    = j_ff - 1'b1;
   assign j_m2    = j_ff - 2'd2;
   assign v_entry = '{score: v_score_ff, idx: i_ff[IDX_W-1:0]};

   always_ff @(posedge clock) begin
      if (box_we) begin
         box_mem[box_wa]   <= box_wd;
         score_mem[box_wa] <= req_data.objectness;
      end
      if (sort_we) begin
         sort_mem[sort_wa] <= sort_wd;
      end
      box_rd_ff   <= box_mem[box_ra];
      score_rd_ff <= score_mem[score_ra];
      sort_rd_ff  <= sort_mem[sort_ra];
   end

   assign box_wd = '{h: req_data.box_height, w: req_data.box_width,
                     cy: req_data.center_y, cx: req_data.center_x};

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      v_score_in  = v_score_ff;
      supp_in     = supp_ff;
      box_a_in    = box_a_ff;
      s1_valid_in = 1'b0;
      s2_valid_in = 1'b0;
      s2_tag_in   = s2_tag_ff;
      pend_in     = 1'b0;
      last_in_nx  = last_ff;
      box_we      = 1'b0;
      box_wa      = count_ff[IDX_W-1:0];
      box_ra      = '0;
      score_ra    = i_ff[IDX_W-1:0];
      sort_we     = 1'b0;
      sort_wa     = '0;
      sort_wd     = v_entry;
      sort_ra     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (count_ff < CNT_W'(MAX_DETS)) begin
                  box_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (req_data.last_in) begin
                  i_in     = '0;
                  state_in = ST_SORT_RD;
               end
            end
         end
         ST_SORT_RD: begin
            state_in = ST_SORT_V;
         end
         ST_SORT_V: begin
            v_score_in = score_rd_ff;
            if (i_ff == '0) begin
               sort_we  = 1'b1;
               sort_wa  = '0;
               sort_wd  = '{score: score_rd_ff, idx: '0};
               i_in     = i_next;
               state_in = (i_next == count_ff) ? ST_ROW_RD : ST_SORT_RD;
               if (i_next == count_ff) i_in = '0;
            end else begin
               sort_ra  = IDX_W'(i_ff - 1'b1);
               j_in     = i_ff;
               state_in = ST_SORT_CMP;
            end
         end
         ST_SORT_CMP: begin
            sort_we = 1'b1;
            sort_wa = j_ff[IDX_W-1:0];
            if (v_score_ff > sort_rd_ff.score) begin
               // shift the lower-ranked entry up one place
               sort_wd = sort_rd_ff;
               j_in    = j_m1;
               if (j_ff > CNT_W'(1)) begin
                  sort_ra = j_m2[IDX_W-1:0];
               end else begin
                  state_in = ST_SORT_PUT;
               end
            end else begin
               sort_wd  = v_entry;
               i_in     = (i_next == count_ff) ? '0 : i_next;
               state_in = (i_next == count_ff) ? ST_ROW_RD : ST_SORT_RD;
            end
         end
         ST_SORT_PUT: begin
            sort_we  = 1'b1;
            sort_wa  = '0;
            sort_wd  = v_entry;
            i_in     = (i_next == count_ff) ? '0 : i_next;
            state_in = (i_next == count_ff) ? ST_ROW_RD : ST_SORT_RD;
         end
         ST_ROW_RD: begin
            if (i_ff == count_ff) begin
               i_in     = '0;
               state_in = ST_OUT;
            end else begin
               sort_ra  = i_ff[IDX_W-1:0];
               state_in = ST_ROW_CHK;
            end
         end
         ST_ROW_CHK: begin
            if (sort_rd_ff.score == 16'd0 || supp_ff[sort_rd_ff.idx]) begin
               i_in     = i_next;
               state_in = ST_ROW_RD;
            end else begin
               box_ra   = sort_rd_ff.idx;
               j_in     = i_next;
               state_in = ST_ROW_BOX;
            end
         end
         ST_ROW_BOX: begin
            box_a_in = box_rd_ff;
            state_in = ST_STREAM;
         end
         ST_STREAM: begin
            if (j_ff < count_ff) begin
               sort_ra     = j_ff[IDX_W-1:0];
               j_in        = j_ff + 1'b1;
               s1_valid_in = 1'b1;
            end else if (!s1_valid_ff && !s2_valid_ff && !iou_rsp.busy) begin
               i_in     = i_next;
               state_in = ST_ROW_RD;
            end
         end
         ST_OUT: begin
            if (i_ff < count_ff) begin
               sort_ra    = i_ff[IDX_W-1:0];
               pend_in    = 1'b1;
               last_in_nx = (i_next == count_ff);
               i_in       = i_next;
            end else begin
               // the last result shows this cycle; empty the set
               supp_in  = '0;
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // candidate pipeline: order entry, then box fetch
      if (s1_valid_ff) begin
         box_ra      = sort_rd_ff.idx;
         s2_tag_in   = sort_rd_ff.idx;
         s2_valid_in = (sort_rd_ff.score != 16'd0) && !supp_ff[sort_rd_ff.idx];
      end
      if (iou_rsp.valid && iou_rsp.hit) begin
         supp_in[iou_rsp.tag] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         supp_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         pend_ff     <= 1'b0;
         thr_ff      <= IOU_THRESHOLD_RESET;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         supp_ff     <= supp_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         pend_ff     <= pend_in;
         if (csr_we) thr_ff <= csr_wdata;
      end
      i_ff       <= i_in;
      j_ff       <= j_in;
      v_score_ff <= v_score_in;
      box_a_ff   <= box_a_in;
      s2_tag_ff  <= s2_tag_in;
      last_ff    <= last_in_nx;
   end

   assign iou_req = '{valid: s2_valid_ff, tag: s2_tag_ff, a: box_a_ff, b: box_rd_ff};

   onms_iou u_iou (
      .clock (clock),
      .reset (reset),
      .thr   (thr_ff),
      .req   (iou_req),
      .rsp   (iou_rsp)
   );

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = pend_ff;
   assign rsp_data.det_index  = 6'(sort_rd_ff.idx);
   assign rsp_data.kept       = (sort_rd_ff.score != 16'd0) && !supp_ff[sort_rd_ff.idx];
   assign rsp_data.score_out  = rsp_data.kept ? sort_rd_ff.score : 16'd0;
   assign rsp_data.last_out   = last_ff;

`ifndef SYNTHESIS
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result transfer while idle");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_DETS)) else $error("load count beyond store depth");
   a_flags_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (supp_ff == '0)) else $error("suppression flags left set");
   a_iou_in_stream: assert property (@(posedge clock) disable iff (reset)
      iou_rsp.valid |-> (state_ff == ST_STREAM)) else $error("IoU result outside stream");
`endif

endmodule

### test/tb_objectness_nms_unit.sv
// Testbench for objectness_nms_unit: directed and random detection sets checked against a predictor.
`timescale 1ns / 100ps

module tb_objectness_nms_unit;
   import onms_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   // Predictor state: its own copy of the threshold and the current set.
   logic [15:0] model_threshold = IOU_THRESHOLD_RESET;
   box_type     set_boxes[MAX_DETS];
   logic [15:0] set_scores[MAX_DETS];
   int          set_count = 0;

   rsp_type expected_results[$];
   int      mismatch_count = 0;
   int      idle_cycles = 0;
   int      stall_count = 0;

   objectness_nms_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Overlap test with doubled edges; true means the lower box gets suppressed.
   function automatic bit overlaps_too_much(box_type a, box_type b);
      longint ax, ay, aw, ah, bx, by, bw, bh, lx, rx, ly, ry, ow, oh, inter, uni;
      ax = a.cx; ay = a.cy; aw = a.w; ah = a.h;
      bx = b.cx; by = b.cy; bw = b.w; bh = b.h;
      lx = (2*ax - aw) > (2*bx - bw) ? (2*ax - aw) : (2*bx - bw);
      rx = (2*ax + aw) < (2*bx + bw) ? (2*ax + aw) : (2*bx + bw);
      ly = (2*ay - ah) > (2*by - bh) ? (2*ay - ah) : (2*by - bh);
      ry = (2*ay + ah) < (2*by + bh) ? (2*ay + ah) : (2*by + bh);
      ow = rx - lx;
      oh = ry - ly;
      inter = (ow < 0 || oh < 0) ? 0 : ow * oh;
      uni = 4*aw*ah + 4*bw*bh - inter;
      if (uni <= 0) return 1'b0;
      return inter * 65536 > longint'(model_threshold) * uni;
   endfunction

   // Load one detection; on last_in rank the set, suppress and queue the results.
   task automatic predict_detection(req_type d);
      int      rank[MAX_DETS];
      bit      dropped[MAX_DETS];
      int      i, j, v, p, q;
      rsp_type r;
      if (set_count < MAX_DETS) begin
         set_boxes[set_count] = '{h: d.box_height, w: d.box_width, cy: d.center_y,
                                  cx: d.center_x};
         set_scores[set_count] = d.objectness;
         set_count++;
      end
      if (!d.last_in) return;
      for (i = 0; i < set_count; i++) begin
         v = i;
         j = i;
         while (j > 0 && (set_scores[v] > set_scores[rank[j-1]] ||
                (set_scores[v] == set_scores[rank[j-1]] && v < rank[j-1]))) begin
            rank[j] = rank[j-1];
            j--;
         end
         rank[j] = v;
         dropped[i] = 1'b0;
      end
      for (i = 0; i < set_count; i++) begin
         p = rank[i];
         if (set_scores[p] == 0 || dropped[p]) continue;
         for (j = i + 1; j < set_count; j++) begin
            q = rank[j];
            if (set_scores[q] == 0 || dropped[q]) continue;
            if (overlaps_too_much(set_boxes[p], set_boxes[q])) dropped[q] = 1'b1;
         end
      end
      for (i = 0; i < set_count; i++) begin
         p = rank[i];
         r.det_index = p[5:0];
         r.kept      = set_scores[p] != 0 && !dropped[p];
         r.score_out = r.kept ? set_scores[p] : 16'd0;
         r.last_out  = (i + 1 == set_count);
         expected_results.push_back(r);
      end
      set_count = 0;
   endtask

   // Compare every strobed result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %p", rsp_data);
         end else begin
            rsp_type want;
            want = expected_results.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", want, rsp_data);
            end
         end
      end
   end

   // Watchdog: count cycles with no transfer in either direction.
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Send one detection: hold start until the transfer, then drop it unless a
   // burst continues; further gaps come from the burst pattern.
   task automatic send_detection(req_type d, bit keep_start);
      start    <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_detection(d);
      if (!keep_start) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_with_gaps(req_type d);
      bit more;
      more = stall_count > 0;
      if (stall_count > 0) stall_count--;
      send_detection(d, more);
      if (!more) begin
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0) @(posedge clock);
         stall_count = $urandom_range(0, 8);
      end
   endtask

   // Wait out a run: all results in, then a margin before touching the register.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0 || busy) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      model_threshold = value;
   endtask

   function automatic req_type random_detection(bit last, bit clustered);
      req_type d;
      d.center_x   = clustered ? 16'($urandom_range(30000, 34000)) : 16'($urandom);
      d.center_y   = clustered ? 16'($urandom_range(30000, 34000)) : 16'($urandom);
      d.box_width  = clustered ? 16'($urandom_range(4000, 12000)) : 16'($urandom);
      d.box_height = clustered ? 16'($urandom_range(4000, 12000)) : 16'($urandom);
      case ($urandom_range(0, 7))
         0:       d.objectness = 16'd0;
         1:       d.objectness = 16'hFFFF;
         2:       d.objectness = 16'($urandom_range(0, 3) * 1000);
         default: d.objectness = 16'($urandom);
      endcase
      d.last_in = last;
      return d;
   endfunction

   function automatic req_type make_det(int cx, int cy, int w, int h, int s, bit last);
      req_type d;
      d = '{center_x: 16'(cx), center_y: 16'(cy), box_width: 16'(w),
            box_height: 16'(h), objectness: 16'(s), last_in: last};
      return d;
   endfunction

   // Ties, zero scores, zero-size boxes, full overlap and extremes.
   task automatic test_directed();
      send_detection(make_det(32768, 32768, 8000, 8000, 40000, 0), 0);
      send_detection(make_det(32768, 32768, 8000, 8000, 40000, 0), 0);
      send_detection(make_det(33000, 32768, 8000, 8000, 50000, 0), 0);
      send_detection(make_det(100, 100, 0, 0, 30000, 0), 0);
      send_detection(make_det(100, 100, 0, 0, 30000, 0), 0);
      send_detection(make_det(65535, 65535, 65535, 65535, 65535, 0), 0);
      send_detection(make_det(0, 0, 65535, 65535, 0, 0), 0);
      send_detection(make_det(10000, 50000, 2000, 3000, 1, 1), 0);
      wait_drained();
      send_detection(make_det(0, 0, 0, 0, 0, 1), 0);
      wait_drained();
      send_detection(make_det(0, 0, 65535, 65535, 65535, 0), 0);
      send_detection(make_det(65535, 65535, 65535, 65535, 1, 1), 0);
      wait_drained();
   endtask

   // Fill past the store size so the extra detections are dropped.
   task automatic test_full_store();
      for (int i = 0; i < MAX_DETS + 3; i++)
         send_with_gaps(random_detection(i == MAX_DETS + 2, i % 3 == 0));
      wait_drained();
   endtask

   task automatic test_random_sets(int item_budget);
      int n;
      while (item_budget > 0) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         for (int i = 0; i < n; i++)
            send_with_gaps(random_detection(i == n - 1, $urandom_range(0, 2) != 0));
         item_budget -= n;
         if ($urandom_range(0, 4) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_threshold(16'd0);
      test_directed();
      write_threshold(16'hFFFF);
      test_directed();
      write_threshold(IOU_THRESHOLD_RESET);
      test_full_store();
      write_threshold(16'd20000);
      test_random_sets(130);
      write_threshold(16'($urandom));
      test_random_sets(110);
      write_threshold(16'd0);
      test_random_sets(60);
      write_threshold(16'd50000);
      test_random_sets(40);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
